// ===== rtl/core/fqrc_pkg.sv =====
// Package for the FIFO queue with reverse and counts.
// Holds the request and response types, request kinds, error codes and sequencer states.
// Depends on nothing; every other file in rtl/core imports it.
package fqrc_pkg;

  // Default number of entries in the ring store.
  localparam int unsigned DEFAULT_DEPTH = 16;

  // Request kinds.
  localparam logic [2:0] KIND_PUSH      = 3'd0;
  localparam logic [2:0] KIND_POP       = 3'd1;
  localparam logic [2:0] KIND_REVERSE   = 3'd2;
  localparam logic [2:0] KIND_COUNT_GT  = 3'd3;
  localparam logic [2:0] KIND_COUNT_EVN = 3'd4;

  // Error codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_POP_EMPTY = 2'd1;
  localparam logic [1:0] ERR_PUSH_FULL = 2'd2;

  // One incoming request.
  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] push_value;
    logic signed [31:0] threshold;
  } in_req_t;

  // One outgoing response.
  typedef struct packed {
    logic signed [31:0] result_value;
    logic               is_empty;
    logic               is_full;
    logic [1:0]         error_code;
  } out_rsp_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP,
    ST_WALK
  } state_t;

endpackage

// ===== rtl/core/fqrc_store.sv =====
// Ring store of the queue: one write port and one read port with registered read data.
// Depends on fqrc_pkg for the default depth.
module fqrc_store
  import fqrc_pkg::*;
#(
  parameter int unsigned DEPTH = DEFAULT_DEPTH,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the read data is registered.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/fqrc_slot.sv =====
// Shared slot unit: maps a base slot and a logical offset to a physical ring slot.
// Walks upward in normal order and downward when reversed. Depends on fqrc_pkg.
module fqrc_slot
  import fqrc_pkg::*;
#(
  parameter int unsigned DEPTH = DEFAULT_DEPTH,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic [AW-1:0] base,
  input  logic [AW-1:0] offset,
  input  logic          rev,
  output logic [AW-1:0] slot
);

  localparam logic [AW:0] DEPTH_V = (AW + 1)'(DEPTH);

  logic [AW:0] raw;
  logic [AW:0] wrapped;

  // Both operands are below DEPTH, so one conditional subtract wraps the result.
  always_comb begin
    if (rev) begin
      raw = {1'b0, base} + DEPTH_V - {1'b0, offset};
    end else begin
      raw = {1'b0, base} + {1'b0, offset};
    end
    if (raw >= DEPTH_V) begin
      wrapped = raw - DEPTH_V;
    end else begin
      wrapped = raw;
    end
    slot = wrapped[AW-1:0];
  end

endmodule

// ===== rtl/core/fqrc_ctrl.sv =====
// Sequencer of the queue: pointers, entry count, direction flag, query walk and response.
// Depends on fqrc_pkg and drives the store ports and the shared slot unit inputs.
module fqrc_ctrl
  import fqrc_pkg::*;
#(
  parameter int unsigned DEPTH = DEFAULT_DEPTH,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  in_req_t       in_req,
  output logic          out_valid,
  output out_rsp_t      out_rsp,
  // Store ports.
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [31:0]   wr_data,
  output logic [AW-1:0] rd_addr,
  input  logic [31:0]   rd_data,
  // Shared slot unit.
  output logic [AW-1:0] slot_base,
  output logic [AW-1:0] slot_offset,
  output logic          slot_rev,
  input  logic [AW-1:0] slot
);

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [AW-1:0] ONE_A   = AW'(1);
  localparam int unsigned   PAD_W   = 32 - CW;

  state_t        state_r, state_nxt;
  in_req_t       req_r, req_nxt;
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rev_r, rev_nxt;
  logic [AW-1:0] walk_r, walk_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic [CW-1:0] acc_r, acc_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_rsp_t      out_rsp_r, out_rsp_nxt;

  logic          is_empty;
  logic          is_full;
  logic          hit;
  logic [CW-1:0] total;

  assign is_empty = (count_r == '0);
  assign is_full  = (count_r >= DEPTH_C);

  // Test of one held word for the running query.
  always_comb begin
    if (req_r.kind == KIND_COUNT_GT) begin
      hit = ($signed(rd_data) > req_r.threshold);
    end else begin
      hit = ~rd_data[0];
    end
  end

  assign total = acc_r + CW'(hit);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request, walk and response payload.
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    walk_r    <= walk_nxt;
    left_r    <= left_nxt;
    acc_r     <= acc_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  // Next state and outputs.
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    rev_nxt       = rev_r;
    walk_nxt      = walk_r;
    left_nxt      = left_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    wr_en         = 1'b0;
    wr_addr       = slot;
    wr_data       = req_r.push_value;
    rd_addr       = front_r;
    slot_base     = front_r;
    slot_offset   = ONE_A;
    slot_rev      = rev_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        out_rsp_nxt.result_value = '0;
        out_rsp_nxt.error_code   = ERR_NONE;
        out_valid_nxt            = 1'b1;
        state_nxt                = ST_IDLE;
        unique case (req_r.kind)
          KIND_PUSH: begin
            slot_offset = count_r[AW-1:0];
            if (is_full) begin
              out_rsp_nxt.error_code = ERR_PUSH_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + ONE_C;
            end
          end
          KIND_POP: begin
            // The front word is read here and returned from ST_POP.
            if (is_empty) begin
              out_rsp_nxt.error_code = ERR_POP_EMPTY;
            end else begin
              out_valid_nxt = 1'b0;
              state_nxt     = ST_POP;
            end
          end
          KIND_REVERSE: begin
            slot_offset = AW'(count_r - ONE_C);
            if (!is_empty) begin
              front_nxt = slot;
            end
            rev_nxt = ~rev_r;
          end
          KIND_COUNT_GT, KIND_COUNT_EVN: begin
            // Start the walk at the front; the first word arrives next cycle.
            if (!is_empty) begin
              out_valid_nxt = 1'b0;
              walk_nxt      = front_r;
              left_nxt      = count_r;
              acc_nxt       = '0;
              state_nxt     = ST_WALK;
            end
          end
          default: begin
          end
        endcase
        out_rsp_nxt.is_empty = (count_nxt == '0);
        out_rsp_nxt.is_full  = (count_nxt >= DEPTH_C);
      end

      ST_POP: begin
        front_nxt                = slot;
        count_nxt                = count_r - ONE_C;
        out_rsp_nxt.result_value = rd_data;
        out_rsp_nxt.error_code   = ERR_NONE;
        out_rsp_nxt.is_empty     = (count_nxt == '0);
        out_rsp_nxt.is_full      = 1'b0;
        out_valid_nxt            = 1'b1;
        state_nxt                = ST_IDLE;
      end

      ST_WALK: begin
        // One held word is tested per cycle while the next one is read.
        slot_base = walk_r;
        rd_addr   = slot;
        walk_nxt  = slot;
        acc_nxt   = total;
        left_nxt  = left_r - ONE_C;
        if (left_r == ONE_C) begin
          out_rsp_nxt.result_value = {{PAD_W{1'b0}}, total};
          out_rsp_nxt.error_code   = ERR_NONE;
          out_rsp_nxt.is_empty     = is_empty;
          out_rsp_nxt.is_full      = is_full;
          out_valid_nxt            = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// ===== rtl/core/fifo_queue_with_reverse_and_counts.sv =====
// Top level of the FIFO queue with reverse and counts.
// Instantiates fqrc_store, fqrc_slot and fqrc_ctrl; depends on fqrc_pkg.

// A request is taken when start is high and busy is low. Each request gives exactly one
// response, shown on out_rsp for one cycle with out_valid high, and the receiver cannot
// stall it. Push, reverse, unused kinds and a pop on an empty queue keep busy high for one
// cycle; no new request is taken while busy is high. A pop on a non-empty queue reads the
// front word through the registered read port of the store and keeps busy high through the
// EXEC and POP states. Both count queries walk the held entries one per cycle through that
// single read port and one compare, so busy stays high through the EXEC and WALK states
// (the walk is skipped on an empty queue). The response is shown in the same cycle in which
// busy falls. The store needs no clearing after reset.
module fifo_queue_with_reverse_and_counts
  import fqrc_pkg::*;
#(
  parameter int unsigned DEPTH = DEFAULT_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_rsp_t out_rsp
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;
  logic [AW-1:0] slot_base;
  logic [AW-1:0] slot_offset;
  logic          slot_rev;
  logic [AW-1:0] slot;

  // Ring store.
  fqrc_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared slot arithmetic.
  fqrc_slot #(.DEPTH(DEPTH)) u_slot (
    .base   (slot_base),
    .offset (slot_offset),
    .rev    (slot_rev),
    .slot   (slot)
  );

  // Sequencer.
  fqrc_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_rsp     (out_rsp),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .slot_base   (slot_base),
    .slot_offset (slot_offset),
    .slot_rev    (slot_rev),
    .slot        (slot)
  );

endmodule

// ===== sim/fifo_queue_with_reverse_and_counts_tb.sv =====
// Testbench for fifo_queue_with_reverse_and_counts: directed corner cases, then random traffic.
// A predictor of the ring queue in this file checks every response; depends on fqrc_pkg and
// the RTL.
module fifo_queue_with_reverse_and_counts_tb;
  import fqrc_pkg::*;

  localparam int unsigned DEPTH          = DEFAULT_DEPTH;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 2 * DEPTH + 8;

  // Kinds above count-even are unused; the block answers them with an empty result.
  localparam logic [2:0] KIND_SPARE_FIRST = KIND_COUNT_EVN + 3'd1;
  localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

  // Traffic shapes for the random part.
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_ANY
  } traffic_mix_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_req_t  in_req;
  logic     out_valid;
  out_rsp_t out_rsp;

  // Predicted queue contents and pointers.
  logic signed [31:0] ring_words [DEPTH];
  int unsigned        ring_front;
  int unsigned        ring_count;
  bit                 ring_reversed;

  out_rsp_t    pending_responses [$];
  bit          failed;
  int unsigned stall_cycles;

  fifo_queue_with_reverse_and_counts #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Physical slot of a logical position, counted from the front in the walking direction.
  function automatic int unsigned ring_slot(input int unsigned pos);
    if (ring_reversed) begin
      return (ring_front + DEPTH - (pos % DEPTH)) % DEPTH;
    end
    return (ring_front + (pos % DEPTH)) % DEPTH;
  endfunction

  // Applies one request to the predicted queue and returns the response it must give.
  function automatic out_rsp_t compute_queue_response(input in_req_t req);
    out_rsp_t    rsp;
    int unsigned hits;
    rsp = '0;
    rsp.error_code = ERR_NONE;
    hits = 0;
    case (req.kind)
      KIND_PUSH: begin
        if (ring_count >= DEPTH) begin
          rsp.error_code = ERR_PUSH_FULL;
        end else begin
          ring_words[ring_slot(ring_count)] = req.push_value;
          ring_count++;
        end
      end
      KIND_POP: begin
        if (ring_count == 0) begin
          rsp.error_code = ERR_POP_EMPTY;
        end else begin
          rsp.result_value = ring_words[ring_front];
          ring_front = ring_slot(1);
          ring_count--;
        end
      end
      KIND_REVERSE: begin
        // The front moves to the old back end and the walk turns around.
        if (ring_count > 0) begin
          ring_front = ring_slot(ring_count - 1);
        end
        ring_reversed = !ring_reversed;
      end
      KIND_COUNT_GT: begin
        for (int unsigned i = 0; i < ring_count; i++) begin
          if (ring_words[ring_slot(i)] > req.threshold) begin
            hits++;
          end
        end
        rsp.result_value = hits;
      end
      KIND_COUNT_EVN: begin
        for (int unsigned i = 0; i < ring_count; i++) begin
          if (!ring_words[ring_slot(i)][0]) begin
            hits++;
          end
        end
        rsp.result_value = hits;
      end
      default: begin
      end
    endcase
    rsp.is_empty = (ring_count == 0);
    rsp.is_full  = (ring_count >= DEPTH);
    return rsp;
  endfunction

  function automatic in_req_t make_request(input logic [2:0] kind,
                                           input logic signed [31:0] value,
                                           input logic signed [31:0] bound);
    in_req_t req;
    req.kind       = kind;
    req.push_value = value;
    req.threshold  = bound;
    return req;
  endfunction

  // Mix of full-range, small and extreme words so that counts land on both sides.
  function automatic logic signed [31:0] random_word();
    logic signed [31:0] word;
    case ($urandom_range(3))
      0: word = $signed($urandom_range(16)) - 32'sd8;
      1: begin
        case ($urandom_range(3))
          0: word = WORD_MIN;
          1: word = WORD_MAX;
          2: word = '0;
          default: word = -32'sd1;
        endcase
      end
      default: word = $urandom;
    endcase
    return word;
  endfunction

  // Sends one request and records its predicted response once it is taken.
  task automatic send_request(input in_req_t req);
    @(negedge clk);
    start  = 1'b1;
    in_req = req;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    pending_responses.push_back(compute_queue_response(req));
    @(negedge clk);
    start = 1'b0;
  endtask

  // Every kind but push on an empty queue, unused kinds included.
  task automatic test_empty_queue();
    send_request(make_request(KIND_POP, 32'sd5, '0));
    send_request(make_request(KIND_REVERSE, '0, '0));
    send_request(make_request(KIND_COUNT_GT, '0, WORD_MIN));
    send_request(make_request(KIND_COUNT_EVN, '0, '0));
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) begin
      send_request(make_request(3'(k), WORD_MAX, WORD_MIN));
    end
  endtask

  // Reverse with one entry held keeps the front in place.
  task automatic test_single_entry_reverse();
    send_request(make_request(KIND_PUSH, WORD_MAX, '0));
    send_request(make_request(KIND_REVERSE, '0, '0));
    send_request(make_request(KIND_COUNT_GT, '0, WORD_MIN));
    send_request(make_request(KIND_POP, '0, '0));
  endtask

  // Extreme words and thresholds, then a reverse and a pop from the new front.
  task automatic test_extreme_words();
    send_request(make_request(KIND_PUSH, WORD_MIN, '0));
    send_request(make_request(KIND_PUSH, WORD_MAX, '0));
    send_request(make_request(KIND_PUSH, '0, '0));
    send_request(make_request(KIND_PUSH, -32'sd1, '0));
    send_request(make_request(KIND_PUSH, 32'sd1, '0));
    send_request(make_request(KIND_COUNT_GT, '0, WORD_MIN));
    send_request(make_request(KIND_COUNT_GT, '0, WORD_MAX));
    send_request(make_request(KIND_COUNT_GT, '0, '0));
    send_request(make_request(KIND_COUNT_GT, '0, -32'sd1));
    send_request(make_request(KIND_COUNT_EVN, '0, '0));
    send_request(make_request(KIND_REVERSE, '0, '0));
    send_request(make_request(KIND_POP, '0, '0));
  endtask

  // Random requests in fill, drain and mixed stretches, with the sender idling at idle_pct.
  task automatic test_random_traffic(input int unsigned items, input int unsigned idle_pct);
    traffic_mix_t       mix;
    int unsigned        roll;
    logic [2:0]         kind;
    logic signed [31:0] bound;
    mix = MIX_FILL;
    for (int unsigned n = 0; n < items; n++) begin
      // Change the traffic shape once the queue reaches an end, or now and then.
      if (mix == MIX_FILL && ring_count == DEPTH && $urandom_range(3) == 0) begin
        mix = $urandom_range(1) ? MIX_DRAIN : MIX_ANY;
      end else if (mix == MIX_DRAIN && ring_count == 0 && $urandom_range(3) == 0) begin
        mix = $urandom_range(1) ? MIX_FILL : MIX_ANY;
      end else if (mix == MIX_ANY && $urandom_range(31) == 0) begin
        mix = $urandom_range(1) ? MIX_FILL : MIX_DRAIN;
      end
      roll = $urandom_range(99);
      case (mix)
        MIX_FILL:  kind = (roll < 80) ? KIND_PUSH : (roll < 85) ? KIND_POP :
                          (roll < 90) ? KIND_REVERSE : (roll < 94) ? KIND_COUNT_GT :
                          (roll < 98) ? KIND_COUNT_EVN : KIND_SPARE_FIRST;
        MIX_DRAIN: kind = (roll < 75) ? KIND_POP : (roll < 82) ? KIND_PUSH :
                          (roll < 88) ? KIND_REVERSE : (roll < 93) ? KIND_COUNT_GT :
                          (roll < 97) ? KIND_COUNT_EVN : KIND_SPARE_FIRST;
        default:   kind = (roll < 30) ? KIND_PUSH : (roll < 55) ? KIND_POP :
                          (roll < 67) ? KIND_REVERSE : (roll < 80) ? KIND_COUNT_GT :
                          (roll < 93) ? KIND_COUNT_EVN : KIND_SPARE_FIRST;
      endcase
      if (kind == KIND_SPARE_FIRST) begin
        kind = KIND_SPARE_FIRST + 3'($urandom_range(KIND_SPARE_LAST - KIND_SPARE_FIRST));
      end
      // Thresholds often equal a held word so that the strict compare is exercised.
      if (ring_count > 0 && $urandom_range(2) == 0) begin
        bound = ring_words[ring_slot($urandom_range(ring_count - 1))];
      end else begin
        bound = random_word();
      end
      while ($urandom_range(99) < idle_pct) begin
        @(negedge clk);
      end
      send_request(make_request(kind, random_word(), bound));
    end
  endtask

  // Compares each response with the oldest prediction.
  always @(posedge clk) begin : check_responses
    out_rsp_t want;
    if (rst_n && out_valid) begin
      if (pending_responses.size() == 0) begin
        $error("response with none expected: result_value %0d", out_rsp.result_value);
        failed = 1'b1;
      end else begin
        want = pending_responses.pop_front();
        if (out_rsp.result_value !== want.result_value) begin
          $error("result_value: expected %0d, got %0d", want.result_value,
                 out_rsp.result_value);
          failed = 1'b1;
        end
        if (out_rsp.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0b, got %0b", want.is_empty, out_rsp.is_empty);
          failed = 1'b1;
        end
        if (out_rsp.is_full !== want.is_full) begin
          $error("is_full: expected %0b, got %0b", want.is_full, out_rsp.is_full);
          failed = 1'b1;
        end
        if (out_rsp.error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, out_rsp.error_code);
          failed = 1'b1;
        end
      end
    end
  end

  // Ends the run when neither a request nor a response moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Reset, then the tests in turn, then wait for the last responses.
  initial begin
    start         = 1'b0;
    in_req        = '0;
    rst_n         = 1'b0;
    failed        = 1'b0;
    stall_cycles  = 0;
    ring_front    = 0;
    ring_count    = 0;
    ring_reversed = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_empty_queue();
    test_single_entry_reverse();
    test_extreme_words();
    test_random_traffic(300, 0);
    test_random_traffic(300, 83);
    test_random_traffic(250, 15);
    test_random_traffic(250, 0);

    while (pending_responses.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failed) begin
      $display("SCOREBOARD MISMATCH");
    end else begin
      $display("SCOREBOARD CLEAN");
    end
    $finish;
  end

endmodule
